// ===== rtl/core/b64d_pkg.sv =====
// Shared types, constants and character classification for the base64 stream decoder.
package b64d_pkg;

   // Classification codes beyond the 6-bit alphabet values
   localparam logic [6:0] SKIP_CODE = 7'd64;
   localparam logic [6:0] PAD_CODE  = 7'd65;
   localparam logic [6:0] BAD_CODE  = 7'd66;

   localparam logic [7:0] LINE_FEED = 8'd10;

   // Results one item can cause, and depth of the bundle queue
   localparam int MAX_RESULTS  = 3;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

   // Decoding phase of the current message
   typedef enum logic [1:0] {
      PH_DATA = 2'd0,
      PH_PAD  = 2'd1,
      PH_ERR  = 2'd2
   } phase_type;

   // One result item
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       last_result;
      logic       bad_input;
   } result_type;

   // All results caused by one input item; count is 1..3 when queued
   typedef struct packed {
      logic [1:0]                   count;
      result_type [MAX_RESULTS-1:0] res;
   } bundle_type;

   // Map one character to its 6-bit value or to a special code
   function automatic logic [6:0] classify(input logic [7:0] c);
      logic [6:0] code;
      code = BAD_CODE;
      if (c inside {[8'h41:8'h5A]}) begin
         code = 7'(c - 8'h41);
      end else if (c inside {[8'h61:8'h7A]}) begin
         code = 7'(c - 8'h61 + 8'd26);
      end else if (c inside {[8'h30:8'h39]}) begin
         code = 7'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         code = 7'd62;
      end else if (c == 8'h2F) begin
         code = 7'd63;
      end else if (c == LINE_FEED) begin
         code = SKIP_CODE;
      end else if (c == 8'h3D) begin
         code = PAD_CODE;
      end
      return code;
   endfunction

endpackage

// ===== rtl/core/b64d_front.sv =====
// Front end: accepts characters, classifies them and builds result bundles.
module b64d_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           text_byte,
   input  logic                 end_of_text,
   output logic                 q_push,
   output b64d_pkg::bundle_type q_data
);

   logic [23:0]           acc_ff, acc_in;
   logic [1:0]            cnt_ff, cnt_in;
   b64d_pkg::phase_type   phase_ff, phase_in;
   logic [6:0]            code;
   logic [23:0]           acc_shift;
   logic [1:0]            n;
   b64d_pkg::bundle_type  bundle;

   // Classify the character and work out the next state and results
   always_comb begin
      code      = b64d_pkg::classify(text_byte);
      acc_shift = {acc_ff[17:0], code[5:0]};
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      phase_in  = phase_ff;
      n         = 2'd0;
      bundle    = '0;

      if (phase_ff == b64d_pkg::PH_DATA) begin
         if (code == b64d_pkg::BAD_CODE) begin
            phase_in = b64d_pkg::PH_ERR;
         end else if (code == b64d_pkg::PAD_CODE) begin
            phase_in = b64d_pkg::PH_PAD;
         end else if (code != b64d_pkg::SKIP_CODE) begin
            if (cnt_ff == 2'd3) begin
               // complete group: emit three bytes and clear
               bundle.res[0] = '{acc_shift[23:16], 1'b1, 1'b0, 1'b0};
               bundle.res[1] = '{acc_shift[15:8],  1'b1, 1'b0, 1'b0};
               bundle.res[2] = '{acc_shift[7:0],   1'b1, 1'b0, 1'b0};
               n      = 2'd3;
               acc_in = '0;
               cnt_in = 2'd0;
            end else begin
               acc_in = acc_shift;
               cnt_in = cnt_ff + 2'd1;
            end
         end
      end

      // Close the message: flush, flag error, mark the last byte or give a bare end item
      if (end_of_text) begin
         if (phase_in != b64d_pkg::PH_DATA && phase_in != b64d_pkg::PH_PAD) begin
            bundle.res[0] = '{8'd0, 1'b0, 1'b1, 1'b1};
            n = 2'd1;
         end else if (n == 2'd3) begin
            bundle.res[2].last_result = 1'b1;
         end else if (cnt_in == 2'd3) begin
            bundle.res[0] = '{acc_in[17:10], 1'b1, 1'b0, 1'b0};
            bundle.res[1] = '{acc_in[9:2],   1'b1, 1'b1, 1'b0};
            n = 2'd2;
         end else if (cnt_in == 2'd2) begin
            bundle.res[0] = '{acc_in[11:4], 1'b1, 1'b1, 1'b0};
            n = 2'd1;
         end else begin
            bundle.res[0] = '{8'd0, 1'b0, 1'b1, 1'b0};
            n = 2'd1;
         end
         acc_in   = '0;
         cnt_in   = 2'd0;
         phase_in = b64d_pkg::PH_DATA;
      end

      bundle.count = n;
      q_data       = bundle;
      q_push       = accept && (n != 2'd0);
   end

   // Hold decoder state, advance on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         cnt_ff   <= 2'd0;
         phase_ff <= b64d_pkg::PH_DATA;
      end else if (accept) begin
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         phase_ff <= phase_in;
      end
   end

endmodule

// ===== rtl/core/b64d_queue.sv =====
// Short queue of result bundles between the front and the back end.
module b64d_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  b64d_pkg::bundle_type push_data,
   output logic                 full,
   input  logic                 pop,
   output b64d_pkg::bundle_type head,
   output logic                 empty
);

   b64d_pkg::bundle_type                  slot_ff [b64d_pkg::QUEUE_DEPTH];
   logic [b64d_pkg::QUEUE_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [b64d_pkg::QUEUE_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [b64d_pkg::QUEUE_CNT_W-1:0]      cnt_ff, cnt_in;
   logic                                  do_push, do_pop;

   assign full  = (cnt_ff == b64d_pkg::QUEUE_CNT_W'(b64d_pkg::QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the bundle
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/b64d_back.sv =====
// Back end: splits queued bundles into single result items in an output register.
module b64d_back (
   input  logic                 clock,
   input  logic                 reset,
   input  b64d_pkg::bundle_type head,
   input  logic                 q_empty,
   output logic                 q_pop,
   input  logic                 rsp_pop,
   output logic                 rsp_empty,
   output b64d_pkg::result_type rsp_data
);

   logic [1:0]           idx_ff, idx_in;
   logic                 valid_ff, valid_in;
   b64d_pkg::result_type out_ff, out_in;
   logic                 load;

   assign rsp_empty = !valid_ff;
   assign rsp_data  = out_ff;

   // Load the next result whenever the output register is free or draining
   always_comb begin
      load     = !q_empty && (!valid_ff || rsp_pop);
      idx_in   = idx_ff;
      valid_in = valid_ff;
      out_in   = out_ff;
      q_pop    = 1'b0;
      if (load) begin
         out_in   = head.res[idx_ff];
         valid_in = 1'b1;
         if (idx_ff == head.count - 2'd1) begin
            idx_in = 2'd0;
            q_pop  = 1'b1;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end else if (valid_ff && rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Hold the payload
   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

// ===== rtl/core/base64_stream_decoder.sv =====
// Base64 stream decoder: one character in, one decoded result item out per cycle, unless stalled.
// A character's results are registered in the bundle queue, then in the output register.
// One character a cycle in unless req_full; one item a cycle out of the output register on rsp_pop.
// A group of four values gives three items, drained one by one by the single output register.
// Reset (synchronous, active high) clears decoder state, the bundle queue and the output.
module base64_stream_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_text_byte,
   input  logic       req_end_of_text,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_last_result,
   output logic       rsp_bad_input
);

   logic                 accept;
   logic                 q_push, q_full, q_pop, q_empty;
   b64d_pkg::bundle_type q_in, q_head;
   b64d_pkg::result_type rsp_data;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   b64d_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .text_byte   (req_text_byte),
      .end_of_text (req_end_of_text),
      .q_push      (q_push),
      .q_data      (q_in)
   );

   b64d_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   b64d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

   assign rsp_out_byte    = rsp_data.out_byte;
   assign rsp_byte_valid  = rsp_data.byte_valid;
   assign rsp_last_result = rsp_data.last_result;
   assign rsp_bad_input   = rsp_data.bad_input;

   // The front never pushes a bundle into a full queue
   assert property (@(posedge clock) disable iff (reset) !(q_push && q_full))
      else $error("bundle pushed into full queue");

   // An error is only reported on the final item of a message
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_bad_input) |-> (rsp_last_result && !rsp_byte_valid))
      else $error("error flag on a non-final or data item");

   // An item without data carries a zero byte
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_byte_valid) |-> (rsp_out_byte == 8'd0))
      else $error("non-zero byte on an empty item");

   // Reset leaves no result waiting
   assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result present after reset");

endmodule

// ===== tb/base64_stream_decoder_checker.sv =====
// Checker for the base64 stream decoder: predicts result items from accepted characters and compares.
module base64_stream_decoder_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic       req_full,
   input  logic [7:0] req_text_byte,
   input  logic       req_end_of_text,
   input  logic       rsp_empty,
   input  logic       rsp_pop,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_byte_valid,
   input  logic       rsp_last_result,
   input  logic       rsp_bad_input,
   output int         fail_count,
   output int         pending_count
);

   // Predicted decoder state
   logic [23:0]          group_bits;
   logic [1:0]           group_fill;
   b64d_pkg::phase_type  msg_phase;

   b64d_pkg::result_type expected_items[$];
   int                   n_fail    = 0;
   int                   n_pending = 0;

   assign fail_count    = n_fail;
   assign pending_count = n_pending;

   // Give the 6-bit value of a character, or a skip, pad or bad code
   function automatic logic [6:0] char_value(input logic [7:0] c);
      logic [6:0] v;
      v = b64d_pkg::BAD_CODE;
      if (c >= "A" && c <= "Z") v = 7'(c - "A");
      if (c >= "a" && c <= "z") v = 7'(c - "a") + 7'd26;
      if (c >= "0" && c <= "9") v = 7'(c - "0") + 7'd52;
      if (c == "+")             v = 7'd62;
      if (c == "/")             v = 7'd63;
      if (c == 8'd10)           v = b64d_pkg::SKIP_CODE;
      if (c == "=")             v = b64d_pkg::PAD_CODE;
      return v;
   endfunction

   function automatic b64d_pkg::result_type make_item(input logic [7:0] b, input logic v,
                                                      input logic l, input logic e);
      b64d_pkg::result_type r;
      r.out_byte    = b;
      r.byte_valid  = v;
      r.last_result = l;
      r.bad_input   = e;
      return r;
   endfunction

   // Append one predicted item at the tail
   task automatic queue_item(input b64d_pkg::result_type r);
      expected_items.insert(expected_items.size(), r);
   endtask

   // Decode one accepted character and queue the items it causes
   task automatic decode_char(input logic [7:0] c, input logic eot);
      logic [6:0] v;
      bit         full_group;
      full_group = 1'b0;
      if (msg_phase == b64d_pkg::PH_DATA) begin
         v = char_value(c);
         if (v == b64d_pkg::BAD_CODE) begin
            msg_phase = b64d_pkg::PH_ERR;
         end else if (v == b64d_pkg::PAD_CODE) begin
            msg_phase = b64d_pkg::PH_PAD;
         end else if (v != b64d_pkg::SKIP_CODE) begin
            group_bits = {group_bits[17:0], v[5:0]};
            if (group_fill == 2'd3) begin
               // Emit the full group; the end mark lands on its third byte
               queue_item(make_item(group_bits[23:16], 1'b1, 1'b0, 1'b0));
               queue_item(make_item(group_bits[15:8], 1'b1, 1'b0, 1'b0));
               queue_item(make_item(group_bits[7:0], 1'b1, eot, 1'b0));
               group_bits = '0;
               group_fill = '0;
               full_group = 1'b1;
            end else begin
               group_fill = group_fill + 2'd1;
            end
         end
      end
      if (eot) begin
         // Close the message: error mark, flush of a partial group, or a bare end
         if (msg_phase != b64d_pkg::PH_DATA && msg_phase != b64d_pkg::PH_PAD) begin
            queue_item(make_item(8'd0, 1'b0, 1'b1, 1'b1));
         end else if (!full_group) begin
            if (group_fill == 2'd3) begin
               queue_item(make_item(group_bits[17:10], 1'b1, 1'b0, 1'b0));
               queue_item(make_item(group_bits[9:2], 1'b1, 1'b1, 1'b0));
            end else if (group_fill == 2'd2) begin
               queue_item(make_item(group_bits[11:4], 1'b1, 1'b1, 1'b0));
            end else begin
               queue_item(make_item(8'd0, 1'b0, 1'b1, 1'b0));
            end
         end
         group_bits = '0;
         group_fill = '0;
         msg_phase  = b64d_pkg::PH_DATA;
      end
   endtask

   // Predict on each accepted character, compare on each accepted result item
   always @(posedge clock) begin
      b64d_pkg::result_type want;
      if (reset) begin
         group_bits = '0;
         group_fill = '0;
         msg_phase  = b64d_pkg::PH_DATA;
         expected_items.delete();
      end else begin
         if (req_push && !req_full) begin
            decode_char(req_text_byte, req_end_of_text);
         end
         if (rsp_pop && !rsp_empty) begin
            if (expected_items.size() == 0) begin
               $error("result item with none expected: out_byte %0h", rsp_out_byte);
               n_fail = n_fail + 1;
            end else begin
               want = expected_items.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  $error("out_byte: expected %0h, got %0h", want.out_byte, rsp_out_byte);
                  n_fail = n_fail + 1;
               end
               if (rsp_byte_valid !== want.byte_valid) begin
                  $error("byte_valid: expected %0b, got %0b", want.byte_valid,
                         rsp_byte_valid);
                  n_fail = n_fail + 1;
               end
               if (rsp_last_result !== want.last_result) begin
                  $error("last_result: expected %0b, got %0b", want.last_result,
                         rsp_last_result);
                  n_fail = n_fail + 1;
               end
               if (rsp_bad_input !== want.bad_input) begin
                  $error("bad_input: expected %0b, got %0b", want.bad_input, rsp_bad_input);
                  n_fail = n_fail + 1;
               end
            end
         end
      end
      n_pending = expected_items.size();
   end

endmodule

// ===== tb/base64_stream_decoder_tb.sv =====
// Testbench top for the base64 stream decoder: clock, reset, character stimulus and verdict.
module base64_stream_decoder_tb;

   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       req_push        = 1'b0;
   logic       req_full;
   logic [7:0] req_text_byte   = 8'd0;
   logic       req_end_of_text = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop         = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_last_result;
   logic       rsp_bad_input;

   int         failures;
   int         pending;
   int         chars_sent = 0;
   bit         calm       = 1'b0;

   base64_stream_decoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_last_result (rsp_last_result),
      .rsp_bad_input   (rsp_bad_input)
   );

   base64_stream_decoder_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_last_result (rsp_last_result),
      .rsp_bad_input   (rsp_bad_input),
      .fail_count      (failures),
      .pending_count   (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the result side now and then, except in the calm stretch
   always @(posedge clock) begin
      rsp_pop <= calm || ($urandom_range(99) >= 6);
   end

   // Hard stop
   initial begin
      #3000000;
      $display("TEST FAILED");
      $finish;
   end

   // Offer one character, idling at random first, and hold it until taken
   task automatic send_char(input logic [7:0] c, input logic eot);
      while (!calm && $urandom_range(99) < 6) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push        <= 1'b1;
      req_text_byte   <= c;
      req_end_of_text <= eot;
      do @(posedge clock); while (req_full);
      chars_sent = chars_sent + 1;
      calm = (chars_sent >= 150 && chars_sent < 260);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_char(s[i], i == s.len() - 1);
      end
   endtask

   function automatic logic [7:0] alphabet_char(input int v);
      logic [7:0] c;
      if (v < 26)       c = 8'("A" + v);
      else if (v < 52)  c = 8'("a" + v - 26);
      else if (v < 62)  c = 8'("0" + v - 52);
      else if (v == 62) c = "+";
      else              c = "/";
      return c;
   endfunction

   // Build one random message, mostly well formed, sometimes broken or pure noise
   task automatic send_random_message();
      logic [7:0] msg[$];
      int         kind;
      int         tail;
      int         pos;
      kind = $urandom_range(99);
      if (kind < 10) begin
         repeat ($urandom_range(1, 6)) msg.insert(msg.size(), 8'($urandom_range(255)));
      end else begin
         repeat ($urandom_range(0, 3) * 4) begin
            if ($urandom_range(9) == 0) msg.insert(msg.size(), b64d_pkg::LINE_FEED);
            msg.insert(msg.size(), alphabet_char($urandom_range(63)));
         end
         tail = $urandom_range(4);
         repeat (tail == 4 ? 0 : tail) msg.insert(msg.size(), alphabet_char($urandom_range(63)));
         if (tail == 2 || tail == 3) begin
            if ($urandom_range(1)) begin
               repeat (4 - tail) msg.insert(msg.size(), "=");
               // Trailing matter after the pad is ignored
               if ($urandom_range(3) == 0) msg.insert(msg.size(), 8'($urandom_range(255)));
            end
         end
         if ($urandom_range(4) == 0) msg.insert(msg.size(), b64d_pkg::LINE_FEED);
         // Break the message with a stray byte
         if (kind >= 88) begin
            pos = $urandom_range(msg.size());
            msg.insert(pos, 8'($urandom_range(255)));
         end
      end
      if (msg.size() == 0) msg.insert(0, b64d_pkg::LINE_FEED);
      foreach (msg[i]) send_char(msg[i], i == msg.size() - 1);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: full group, pads, flushes of two and three values, lone value,
      // bare end, extreme values, carriage return, invalid after the pad, byte extremes
      send_text("TWFu");
      send_text("TWE=");
      send_text("TQ");
      send_text("TWE");
      send_text("A");
      send_text("\n");
      send_text("/+9z");
      send_text("Q\r");
      send_text("=\r");
      send_char(8'h00, 1'b1);
      send_char(8'hFF, 1'b1);

      // Random messages
      while (chars_sent < 400) send_random_message();
      req_push <= 1'b0;

      // Drain, then let any straggler show
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
